// ----- hdl/skl_pkg.sv -----
// shared types, constants and helpers for the sorted key list
package skl_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W = 32;
	localparam int HANDLE_W = 16;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;
	localparam int OP_W = 3;

	typedef enum logic [OP_W-1:0] {
		OP_INS_SORTED = 3'd0,
		OP_INS_AT     = 3'd1,
		OP_APPEND     = 3'd2,
		OP_REMOVE     = 3'd3,
		OP_READ       = 3'd4
	} skl_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} skl_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_FIND,
		S_APPLY
	} skl_state_t;

	typedef struct packed {
		logic sorted;
		logic desc;
	} skl_cmp_t;

	typedef struct packed {
		logic ins;
		logic rem;
		logic ge;
		logic hit;
	} skl_apply_t;

	function automatic logic better(input logic desc, input logic [KEY_W-1:0] a,
			input logic [KEY_W-1:0] b);
		return desc ? (a > b) : (a < b);
	endfunction

endpackage

// ----- hdl/skl_cell.sv -----
// one list cell: holds an entry, flags a match and shifts with its neighbors
module skl_cell #(
	parameter int IDX = 0,
	parameter int WW = 7
) (
	input  logic                          clk,
	input  skl_pkg::skl_cmp_t             cmp,
	input  logic                          cmp_en,
	input  logic [WW-1:0]                 cnt,
	input  logic [WW-1:0]                 tgt,
	input  logic [skl_pkg::KEY_W-1:0]     new_key,
	input  logic [skl_pkg::HANDLE_W-1:0]  new_handle,
	input  logic [skl_pkg::KEY_W-1:0]     left_key,
	input  logic [skl_pkg::HANDLE_W-1:0]  left_handle,
	input  logic [skl_pkg::KEY_W-1:0]     right_key,
	input  logic [skl_pkg::HANDLE_W-1:0]  right_handle,
	input  skl_pkg::skl_apply_t           apply,
	output logic [skl_pkg::KEY_W-1:0]     key_q,
	output logic [skl_pkg::HANDLE_W-1:0]  handle_q,
	output logic                          match_q
);

	localparam logic [WW-1:0] ME = WW'(IDX);

	logic match_d;

	always_comb begin
		match_d = 1'b0;
		if (cmp.sorted) begin
			if (IDX == 0) begin
				match_d = (cnt == '0) || skl_pkg::better(cmp.desc, new_key, key_q);
			end else if (ME < cnt) begin
				match_d = !skl_pkg::better(cmp.desc, key_q, new_key);
			end else begin
				match_d = (ME == cnt);
			end
		end else begin
			match_d = (ME == tgt);
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= match_d;
		end
		if (apply.ins && apply.hit) begin
			key_q    <= new_key;
			handle_q <= new_handle;
		end else if (apply.ins && apply.ge) begin
			key_q    <= left_key;
			handle_q <= left_handle;
		end else if (apply.rem && apply.ge) begin
			key_q    <= right_key;
			handle_q <= right_handle;
		end
	end

endmodule

// ----- hdl/sorted_key_list.sv -----
// top level of the sorted key list: control, cell chain and result register
//
// Usage: one input transaction carries an operation (opcode, key, handle,
// index) and gives exactly one result transaction (position, key_out,
// handle_out, entry_count, status). Both channels use valid and stall; a
// transaction moves at a rising edge with valid high and stall low.
// The list lives in a chain of CAPACITY cells. Each operation runs through
// capture, a compare in every cell, isolating the first matching cell with
// one wide add across the match vector, then for an insert or remove the
// shift of the cells from that one on by one place. The result is valid in
// the cycle after the shift and in_stall is high from capture until the
// shift is done, so no new operation enters before the last has shifted.
// The result register lets the next operation enter while a result waits;
// if the receiver stalls, the shift step waits until the result register
// is free. desc_q is written through cfg_wr_en and cfg_wr_data; the user
// must do so only while idle; the block does not enforce it. Reset empties
// the list and selects ascending order; entry contents are not cleared.
module sorted_key_list #(
	parameter int CAPACITY = skl_pkg::CAPACITY
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [skl_pkg::OP_W-1:0]          opcode,
	input  logic [skl_pkg::KEY_W-1:0]         key,
	input  logic [skl_pkg::HANDLE_W-1:0]      handle,
	input  logic [skl_pkg::INDEX_W-1:0]       index,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [skl_pkg::INDEX_W-1:0]       position,
	output logic [skl_pkg::KEY_W-1:0]         key_out,
	output logic [skl_pkg::HANDLE_W-1:0]      handle_out,
	output logic [skl_pkg::COUNT_W-1:0]       entry_count,
	output logic [1:0]                        status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > skl_pkg::COUNT_W) ? CW : skl_pkg::COUNT_W;

	skl_pkg::skl_state_t state_q, state_d;

	logic                          desc_q;
	logic [CW-1:0]                 cnt_q, cnt_next;
	logic [WW-1:0]                 cnt_w, idx_w;

	skl_pkg::skl_status_t          status_d, status_s1;
	logic                          act_d, ins_d, rem_d, rd_d, sorted_d;
	logic [WW-1:0]                 tgt_d;
	logic                          act_s1, ins_s1, rem_s1, rd_s1, sorted_s1;
	logic [WW-1:0]                 tgt_s1;
	logic [skl_pkg::KEY_W-1:0]     key_s1;
	logic [skl_pkg::HANDLE_W-1:0]  handle_s1;

	logic                          accept, cmp_en, find_en, apply_fire;
	logic [CAPACITY-1:0]           match_vec, onehot_q, ge_mask;
	logic [skl_pkg::KEY_W-1:0]     cell_key [CAPACITY];
	logic [skl_pkg::HANDLE_W-1:0]  cell_handle [CAPACITY];
	skl_pkg::skl_apply_t           app [CAPACITY];
	skl_pkg::skl_cmp_t             cmp;

	logic [skl_pkg::INDEX_W-1:0]   pos_d;
	logic [skl_pkg::KEY_W-1:0]     sel_key;
	logic [skl_pkg::HANDLE_W-1:0]  sel_handle;

	logic                          out_valid_q;
	logic [skl_pkg::INDEX_W-1:0]   position_q;
	logic [skl_pkg::KEY_W-1:0]     key_out_q;
	logic [skl_pkg::HANDLE_W-1:0]  handle_out_q;
	logic [skl_pkg::COUNT_W-1:0]   entry_count_q;
	skl_pkg::skl_status_t          status_q;

	assign cnt_w = WW'(cnt_q);
	assign idx_w = WW'(index);

	// request decode
	always_comb begin
		status_d = skl_pkg::ST_OK;
		act_d    = 1'b0;
		ins_d    = 1'b0;
		rem_d    = 1'b0;
		rd_d     = 1'b0;
		sorted_d = 1'b0;
		tgt_d    = idx_w;
		unique case (skl_pkg::skl_op_t'(opcode)) inside
			skl_pkg::OP_INS_SORTED, skl_pkg::OP_INS_AT, skl_pkg::OP_APPEND: begin
				if (cnt_q == CW'(CAPACITY)) begin
					status_d = skl_pkg::ST_FULL;
				end else if (skl_pkg::skl_op_t'(opcode) == skl_pkg::OP_INS_AT
						&& idx_w > cnt_w) begin
					status_d = skl_pkg::ST_RANGE;
				end else begin
					act_d    = 1'b1;
					ins_d    = 1'b1;
					sorted_d = (skl_pkg::skl_op_t'(opcode) == skl_pkg::OP_INS_SORTED);
					tgt_d    = (skl_pkg::skl_op_t'(opcode) == skl_pkg::OP_INS_AT)
						? idx_w : cnt_w;
				end
			end
			skl_pkg::OP_REMOVE: begin
				if (idx_w >= cnt_w) begin
					status_d = skl_pkg::ST_RANGE;
				end else begin
					act_d = 1'b1;
					rem_d = 1'b1;
				end
			end
			skl_pkg::OP_READ: begin
				if (idx_w >= cnt_w) begin
					status_d = skl_pkg::ST_RANGE;
				end else begin
					act_d = 1'b1;
					rd_d  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skl_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_stall   = 1'b1;
		accept     = 1'b0;
		cmp_en     = 1'b0;
		find_en    = 1'b0;
		apply_fire = 1'b0;
		unique case (state_q)
			skl_pkg::S_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					state_d = skl_pkg::S_CMP;
				end
			end
			skl_pkg::S_CMP: begin
				cmp_en  = 1'b1;
				state_d = skl_pkg::S_FIND;
			end
			skl_pkg::S_FIND: begin
				find_en = 1'b1;
				state_d = skl_pkg::S_APPLY;
			end
			skl_pkg::S_APPLY: begin
				if (!(out_valid_q && out_stall)) begin
					apply_fire = 1'b1;
					state_d    = skl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = skl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			act_s1    <= act_d;
			ins_s1    <= ins_d;
			rem_s1    <= rem_d;
			rd_s1     <= rd_d;
			sorted_s1 <= sorted_d;
			tgt_s1    <= tgt_d;
			key_s1    <= key;
			handle_s1 <= handle;
		end
		if (find_en) begin
			onehot_q <= match_vec & (~match_vec + CAPACITY'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= 1'b0;
		end else if (cfg_wr_en) begin
			desc_q <= cfg_wr_data;
		end
	end

	assign cmp     = '{sorted: sorted_s1, desc: desc_q};
	assign ge_mask = ~(onehot_q - CAPACITY'(1));

	// cell chain
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [skl_pkg::KEY_W-1:0]    lk, rk;
		logic [skl_pkg::HANDLE_W-1:0] lh, rh;
		if (g == 0) begin : g_first
			assign lk = '0;
			assign lh = '0;
		end else begin : g_left
			assign lk = cell_key[g-1];
			assign lh = cell_handle[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign rk = '0;
			assign rh = '0;
		end else begin : g_right
			assign rk = cell_key[g+1];
			assign rh = cell_handle[g+1];
		end
		assign app[g] = '{
			ins: apply_fire && act_s1 && ins_s1,
			rem: apply_fire && act_s1 && rem_s1,
			ge:  ge_mask[g],
			hit: onehot_q[g]
		};
		skl_cell #(
			.IDX(g),
			.WW (WW)
		) u_cell (
			.clk         (clk),
			.cmp         (cmp),
			.cmp_en      (cmp_en),
			.cnt         (cnt_w),
			.tgt         (tgt_s1),
			.new_key     (key_s1),
			.new_handle  (handle_s1),
			.left_key    (lk),
			.left_handle (lh),
			.right_key   (rk),
			.right_handle(rh),
			.apply       (app[g]),
			.key_q       (cell_key[g]),
			.handle_q    (cell_handle[g]),
			.match_q     (match_vec[g])
		);
	end

	// position encode and read select from the isolated cell
	always_comb begin
		pos_d      = '0;
		sel_key    = '0;
		sel_handle = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (onehot_q[i]) begin
				pos_d      = pos_d | skl_pkg::INDEX_W'(i);
				sel_key    = sel_key | cell_key[i];
				sel_handle = sel_handle | cell_handle[i];
			end
		end
	end

	always_comb begin
		cnt_next = cnt_q;
		if (act_s1 && ins_s1) begin
			cnt_next = cnt_q + CW'(1);
		end else if (act_s1 && rem_s1) begin
			cnt_next = cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_fire) begin
				cnt_q       <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply_fire) begin
			position_q    <= act_s1 ? pos_d : '0;
			key_out_q     <= (act_s1 && rd_s1) ? sel_key : '0;
			handle_out_q  <= (act_s1 && rd_s1) ? sel_handle : '0;
			entry_count_q <= skl_pkg::COUNT_W'(cnt_next);
			status_q      <= status_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = position_q;
	assign key_out     = key_out_q;
	assign handle_out  = handle_out_q;
	assign entry_count = entry_count_q;
	assign status      = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	a_onehot_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skl_pkg::S_APPLY) && act_s1 |-> $onehot(onehot_q))
		else $error("no single target cell for an active operation");

	a_count_steady: assert property (@(posedge clk) disable iff (!arst_n)
		!apply_fire |=> $stable(cnt_q))
		else $error("entry count moved outside the shift step");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != skl_pkg::ST_OK)
		|-> (position_q == '0) && (key_out_q == '0) && (handle_out_q == '0))
		else $error("error result carries nonzero fields");

	a_apply_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skl_pkg::S_APPLY) && out_valid_q && out_stall
		|=> (state_q == skl_pkg::S_APPLY) && $stable(cnt_q))
		else $error("shift step ran over a pending result");

endmodule

// ----- tb/sv/sorted_key_list_tb.sv -----
// self-checking testbench for the sorted key list: scoreboard, drivers and run sequence
`timescale 1ns / 100ps

module sorted_key_list_tb;
	import skl_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [INDEX_W-1:0]  position;
		logic [KEY_W-1:0]    key_out;
		logic [HANDLE_W-1:0] handle_out;
		logic [COUNT_W-1:0]  entry_count;
		skl_status_t         status;
	} list_result_t;

	class list_tracker;
		logic [KEY_W-1:0]    keys [CAPACITY];
		logic [HANDLE_W-1:0] handles [CAPACITY];
		int                  count;
		logic                descending;
		list_result_t        pending_results [$];
		int                  errors;
		int                  checked;
		int                  full_seen;
		int                  range_seen;

		function new();
			count = 0;
			descending = 1'b0;
			errors = 0;
			checked = 0;
			full_seen = 0;
			range_seen = 0;
			for (int i = 0; i < CAPACITY; i++) begin
				keys[i] = '0;
				handles[i] = '0;
			end
		endfunction

		function void report_mismatch(string msg);
			if (errors < PRINT_CAP)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endfunction

		function void set_order(logic desc);
			descending = desc;
		endfunction

		function int pending_count();
			return pending_results.size();
		endfunction

		function bit ranks_ahead(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b);
			return descending ? (a > b) : (a < b);
		endfunction

		function int sorted_slot(logic [KEY_W-1:0] k);
			int i;
			if (count == 0 || ranks_ahead(k, keys[0]))
				return 0;
			for (i = 1; i < count; i++) begin
				if (!ranks_ahead(keys[i], k))
					return i;
			end
			return count;
		endfunction

		// accepted input transaction: update the list copy and queue the expected result
		function void note_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
				logic [HANDLE_W-1:0] h, logic [INDEX_W-1:0] idx);
			list_result_t r;
			int pos;
			int i;
			r = '0;
			r.status = ST_OK;
			case (op)
				OP_INS_SORTED, OP_INS_AT, OP_APPEND: begin
					if (count >= CAPACITY) begin
						r.status = ST_FULL;
					end else if (op == OP_INS_AT && int'(idx) > count) begin
						r.status = ST_RANGE;
					end else begin
						if (op == OP_INS_SORTED)
							pos = sorted_slot(k);
						else if (op == OP_INS_AT)
							pos = int'(idx);
						else
							pos = count;
						for (i = count; i > pos; i--) begin
							keys[i] = keys[i-1];
							handles[i] = handles[i-1];
						end
						keys[pos] = k;
						handles[pos] = h;
						count++;
						r.position = INDEX_W'(pos);
					end
				end
				OP_REMOVE: begin
					if (int'(idx) >= count) begin
						r.status = ST_RANGE;
					end else begin
						for (i = int'(idx); i + 1 < count; i++) begin
							keys[i] = keys[i+1];
							handles[i] = handles[i+1];
						end
						count--;
						r.position = idx;
					end
				end
				OP_READ: begin
					if (int'(idx) >= count) begin
						r.status = ST_RANGE;
					end else begin
						r.position = idx;
						r.key_out = keys[idx];
						r.handle_out = handles[idx];
					end
				end
				default: ;
			endcase
			if (r.status == ST_FULL)
				full_seen++;
			if (r.status == ST_RANGE)
				range_seen++;
			r.entry_count = COUNT_W'(count);
			pending_results.push_back(r);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (got.position !== want.position)
				report_mismatch($sformatf("position got %0d want %0d",
					got.position, want.position));
			if (got.key_out !== want.key_out)
				report_mismatch($sformatf("key_out got %h want %h",
					got.key_out, want.key_out));
			if (got.handle_out !== want.handle_out)
				report_mismatch($sformatf("handle_out got %h want %h",
					got.handle_out, want.handle_out));
			if (got.entry_count !== want.entry_count)
				report_mismatch($sformatf("entry_count got %0d want %0d",
					got.entry_count, want.entry_count));
			if (got.status !== want.status)
				report_mismatch($sformatf("status got %0d want %0d",
					got.status, want.status));
		endfunction
	endclass

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_wr_data = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [OP_W-1:0]     opcode = '0;
	logic [KEY_W-1:0]    key = '0;
	logic [HANDLE_W-1:0] handle = '0;
	logic [INDEX_W-1:0]  index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [INDEX_W-1:0]  position;
	logic [KEY_W-1:0]    key_out;
	logic [HANDLE_W-1:0] handle_out;
	logic [COUNT_W-1:0]  entry_count;
	logic [1:0]          status;

	list_tracker tracker;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int pressure_req = 0;
	int items_sent = 0;
	int idle_cycles = 0;

	sorted_key_list uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.key         (key),
		.handle      (handle),
		.index       (index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position),
		.key_out     (key_out),
		.handle_out  (handle_out),
		.entry_count (entry_count),
		.status      (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one input transaction, with optional idle cycles in front
	task automatic send_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [HANDLE_W-1:0] h, input logic [INDEX_W-1:0] idx);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		handle <= h;
		index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_op(op, k, h, idx);
		items_sent++;
	endtask

	task automatic settle_and_configure(input logic desc);
		in_valid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= desc;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.set_order(desc);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r <= 3)
			return KEY_W'($urandom_range(7));
		if (r == 4 && tracker.count > 0)
			return tracker.keys[0];
		if (r == 5 && tracker.count > 0)
			return tracker.keys[$urandom_range(tracker.count - 1)];
		return KEY_W'($urandom());
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index(input bit for_insert);
		if ($urandom_range(9) == 0)
			return INDEX_W'($urandom_range(63));
		if (for_insert)
			return INDEX_W'($urandom_range(tracker.count));
		return (tracker.count > 0) ? INDEX_W'($urandom_range(tracker.count - 1)) : '0;
	endfunction

	task automatic send_insert_random();
		int r;
		r = $urandom_range(9);
		if (r < 6)
			send_op(OP_INS_SORTED, pick_key(), HANDLE_W'($urandom()), INDEX_W'($urandom()));
		else if (r < 8)
			send_op(OP_INS_AT, pick_key(), HANDLE_W'($urandom()), pick_index(1'b1));
		else
			send_op(OP_APPEND, pick_key(), HANDLE_W'($urandom()), INDEX_W'($urandom()));
	endtask

	task automatic send_mixed();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			send_insert_random();
		else if (r < 65)
			send_op(OP_REMOVE, KEY_W'($urandom()), HANDLE_W'($urandom()), pick_index(1'b0));
		else if (r < 95)
			send_op(OP_READ, KEY_W'($urandom()), HANDLE_W'($urandom()), pick_index(1'b0));
		else
			send_op(OP_W'($urandom_range(7, 5)), KEY_W'($urandom()), HANDLE_W'($urandom()),
				INDEX_W'($urandom()));
	endtask

	task automatic fill_list();
		while (tracker.count < CAPACITY)
			send_insert_random();
		repeat (2) send_insert_random();
	endtask

	task automatic run_random(input int n_items);
		int target;
		int c;
		target = items_sent + n_items;
		fill_list();
		while (items_sent < target) begin
			c = $urandom_range(5);
			if (c == 0) begin
				fill_list();
			end else if (c == 1) begin
				while (tracker.count > 0)
					send_op(OP_REMOVE, KEY_W'($urandom()), HANDLE_W'($urandom()),
						pick_index(1'b0));
				send_op(OP_READ, '0, '0, INDEX_W'($urandom()));
				send_op(OP_REMOVE, '0, '0, INDEX_W'($urandom()));
			end else begin
				repeat (20) send_mixed();
			end
		end
	endtask

	task automatic run_directed();
		send_op(OP_READ, '0, '0, 6'd0);
		send_op(OP_REMOVE, '0, '0, 6'd0);
		send_op(OP_INS_AT, 32'd9, 16'd9, 6'd1);
		send_op(OP_INS_AT, 32'd9, 16'd9, 6'd63);
		send_op(OP_INS_SORTED, 32'd100, 16'h0000, 6'd0);
		// equal to the head goes behind it
		send_op(OP_INS_SORTED, 32'd100, 16'hFFFF, 6'd0);
		send_op(OP_INS_SORTED, 32'd50, 16'h0001, 6'd0);
		send_op(OP_INS_SORTED, 32'hFFFF_FFFF, 16'h8000, 6'd63);
		send_op(OP_INS_SORTED, 32'd0, 16'h7FFF, 6'd0);
		// append out of order, then sorted insert over unsorted contents
		send_op(OP_APPEND, 32'd5, 16'h1234, 6'd0);
		send_op(OP_INS_AT, 32'd7, 16'h4321, INDEX_W'(tracker.count));
		send_op(OP_INS_SORTED, 32'd100, 16'h00AA, 6'd0);
		send_op(OP_READ, '0, '0, 6'd0);
		send_op(OP_READ, '0, '0, INDEX_W'(tracker.count - 1));
		send_op(OP_READ, '0, '0, 6'd63);
		send_op(3'd5, 32'hFFFF_FFFF, 16'hFFFF, 6'd63);
		send_op(3'd6, 32'h5555_5555, 16'h5555, 6'd21);
		send_op(3'd7, 32'hAAAA_AAAA, 16'hAAAA, 6'd42);
		send_op(OP_REMOVE, '0, '0, 6'd63);
		send_op(OP_REMOVE, '0, '0, 6'd0);
		send_op(OP_REMOVE, '0, '0, INDEX_W'(tracker.count - 1));
		send_op(OP_INS_AT, 32'hAAAA_5555, 16'h5555, 6'd0);
		send_op(OP_READ, '0, '0, 6'd0);
	endtask

	// result side: check every accepted result, then pick the next stall value
	initial begin
		list_result_t got;
		int hold_left;
		int pressure_seen;
		hold_left = 0;
		pressure_seen = 0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				got.position = position;
				got.key_out = key_out;
				got.handle_out = handle_out;
				got.entry_count = entry_count;
				got.status = skl_status_t'(status);
				tracker.check_result(got);
			end
			if (pressure_req != pressure_seen) begin
				pressure_seen = pressure_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
			end
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("[%0t] watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("sorted_key_list_tb: errors");
		$finish;
	end

	initial begin
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		settle_and_configure(1'b0);
		run_directed();

		// no idling, with a long receiver hold so the block backs up
		settle_and_configure(1'b1);
		send_idle_pct = 0;
		stall_pct = 0;
		pressure_req++;
		run_random(110);

		settle_and_configure(1'b0);
		send_idle_pct = 85;
		stall_pct = 0;
		run_random(110);

		settle_and_configure(1'b1);
		send_idle_pct = 0;
		stall_pct = 85;
		run_random(110);

		settle_and_configure(1'b0);
		send_idle_pct = 25;
		stall_pct = 25;
		run_random(110);

		in_valid <= 1'b0;
		while (tracker.pending_count() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("covered %0d operations, %0d results checked, both key orders",
			items_sent, tracker.checked);
		$display("list-full rejections %0d, out-of-range rejections %0d, mismatches %0d",
			tracker.full_seen, tracker.range_seen, tracker.errors);
		if (tracker.errors == 0) begin
			$display("sorted_key_list_tb: clean");
		end else begin
			$display("sorted_key_list_tb: errors");
		end
		$finish;
	end

endmodule
